/* rtl/ecc_pkg.sv */
package ecc_pkg;

  localparam int FLOOR_W = 6;
  localparam int TICK_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IW  = 2;
  localparam int KIND_W  = 3;
  localparam int MODE_W  = 2;
  localparam int HEAD_W  = 2;
  localparam int PEND_W  = 32;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CALL  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OPEN  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLOSE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ALARM = 3'd4;

  // car modes
  localparam logic [MODE_W-1:0] MODE_WAIT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUN    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BROKEN = 2'd3;

  // headings
  localparam logic [HEAD_W-1:0] HEAD_NONE = 2'd0;
  localparam logic [HEAD_W-1:0] HEAD_UP   = 2'd1;
  localparam logic [HEAD_W-1:0] HEAD_DOWN = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_FLOOR_COUNT = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_FLOOR_TICKS = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_DOOR_TICKS  = 2'd2;

  // reset values of the configuration registers
  localparam logic [FLOOR_W-1:0] RST_FLOOR_COUNT = 6'd20;
  localparam logic [TICK_W-1:0]  RST_FLOOR_TICKS = 16'd7;
  localparam logic [TICK_W-1:0]  RST_DOOR_TICKS  = 16'd20;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FLOOR_W-1:0] call_floor;
  } ecc_in_t;

  typedef struct packed {
    logic [FLOOR_W-1:0] floor_now;
    logic [MODE_W-1:0]  mode;
    logic [HEAD_W-1:0]  heading;
    logic [FLOOR_W-1:0] arrived_floor;
    logic [PEND_W-1:0]  pending_calls;
  } ecc_out_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_step;
    logic pick;
    logic load_out;
  } ecc_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } ecc_stat_t;

endpackage

/* rtl/ecc_dp.sv */
module ecc_dp #(
  parameter int MAX_FLOORS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ecc_pkg::ecc_in_t         in_data,
  output ecc_pkg::ecc_out_t        out_data,
  input  logic                     cfg_we,
  input  logic [ecc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [ecc_pkg::CFG_W-1:0]  cfg_data,
  input  ecc_pkg::ecc_cmd_t        cmd,
  output ecc_pkg::ecc_stat_t       stat
);
  import ecc_pkg::*;

  localparam int DW = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1;
  localparam int WF = FLOOR_W + 1;

  // effective floor count, saturated to [2, MAX_FLOORS]
  function automatic logic [FLOOR_W-1:0] eff_cnt(input logic [FLOOR_W-1:0] fc);
    logic [WF-1:0] n;
    n = {1'b0, fc};
    if (n < WF'(2)) n = WF'(2);
    if (n > WF'(MAX_FLOORS)) n = WF'(MAX_FLOORS);
    return n[FLOOR_W-1:0];
  endfunction

  function automatic logic [TICK_W-1:0] eff_tick(input logic [TICK_W-1:0] t);
    return (t == '0) ? TICK_W'(1) : t;
  endfunction

  // one-hot bit for floor f, zero when f is 0 or above MAX_FLOORS
  function automatic logic [MAX_FLOORS-1:0] floor_bit(input logic [WF-1:0] f);
    logic [MAX_FLOORS-1:0] b;
    for (int i = 0; i < MAX_FLOORS; i++) b[i] = (f == WF'(i + 1));
    return b;
  endfunction

  function automatic logic [MAX_FLOORS-1:0] keep_bits(input logic [FLOOR_W-1:0] n);
    logic [MAX_FLOORS-1:0] b;
    for (int i = 0; i < MAX_FLOORS; i++) b[i] = (i < int'(n));
    return b;
  endfunction

  function automatic logic pend_at(input logic [MAX_FLOORS-1:0] m,
                                   input logic [WF-1:0] f,
                                   input logic [FLOOR_W-1:0] n);
    return (f <= {1'b0, n}) && (|(m & floor_bit(f)));
  endfunction

  // configuration
  logic [FLOOR_W-1:0] fc_r, fc_nxt;
  logic [TICK_W-1:0]  ft_r, ft_nxt;
  logic [TICK_W-1:0]  dt_r, dt_nxt;

  // car state
  logic [FLOOR_W-1:0]    car_r, car_nxt;
  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [HEAD_W-1:0]     head_r, head_nxt;
  logic [MAX_FLOORS-1:0] mask_r, mask_nxt;
  logic [FLOOR_W-1:0]    goal_r, goal_nxt;
  logic [TICK_W-1:0]     travel_r, travel_nxt;
  logic [TICK_W-1:0]     door_r, door_nxt;
  logic [FLOOR_W-1:0]    served_r, served_nxt;

  // event and scan registers
  ecc_in_t            ev_r;
  ecc_out_t           out_r;
  logic [DW-1:0]      d_r, d_nxt;
  logic               lo_hit_r, lo_hit_nxt, hi_hit_r, hi_hit_nxt;
  logic [FLOOR_W-1:0] lo_f_r, lo_f_nxt, hi_f_r, hi_f_nxt;

  logic [FLOOR_W-1:0] n_eff;
  logic [TICK_W-1:0]  travel_inc, door_inc;
  logic [FLOOR_W-1:0] moved;
  logic               call_ok;

  logic               lo_ok, lo_now, hi_now, any_lo, any_hi, last_d;
  logic [FLOOR_W-1:0] lo_f_now, lo_sel, hi_sel;
  logic [WF-1:0]      hi_f_now;
  logic               tgt_go;
  logic [FLOOR_W-1:0] tgt_f;

  logic               trip_go, arr_go;
  logic [FLOOR_W-1:0] trip_f, arr_f;
  logic [MAX_FLOORS+PEND_W-1:0] mask_wide;

  assign n_eff      = eff_cnt(fc_r);
  assign travel_inc = travel_r + TICK_W'(1);
  assign door_inc   = door_r + TICK_W'(1);
  assign call_ok    = (ev_r.call_floor != '0) && (ev_r.call_floor <= n_eff);

  always_comb begin
    if (goal_r > car_r) moved = car_r + FLOOR_W'(1);
    else if (goal_r < car_r) moved = car_r - FLOOR_W'(1);
    else moved = car_r;
  end

  // nearest-call scan, one distance per cycle outward from the car
  assign lo_ok    = {1'b0, car_r} > WF'(d_r);
  assign lo_f_now = car_r - FLOOR_W'(d_r);
  assign hi_f_now = {1'b0, car_r} + WF'(d_r);
  assign lo_now   = lo_ok && pend_at(mask_r, {1'b0, lo_f_now}, n_eff);
  assign hi_now   = pend_at(mask_r, hi_f_now, n_eff);
  assign any_lo   = lo_hit_r || lo_now;
  assign any_hi   = hi_hit_r || hi_now;
  assign lo_sel   = lo_hit_r ? lo_f_r : lo_f_now;
  assign hi_sel   = hi_hit_r ? hi_f_r : hi_f_now[FLOOR_W-1:0];
  assign last_d   = (d_r == DW'(MAX_FLOORS - 1));

  always_comb begin
    stat.need_scan = (mode_r == MODE_OPEN) &&
                     ((ev_r.kind == KIND_CLOSE) ||
                      ((ev_r.kind == KIND_TICK) && (door_inc >= eff_tick(dt_r))));
    tgt_go = 1'b0;
    tgt_f  = lo_sel;
    priority case (head_r)
      HEAD_UP: begin
        stat.scan_done = any_hi || last_d;
        if (any_hi) begin
          tgt_go = 1'b1;
          tgt_f  = hi_sel;
        end else if (any_lo) begin
          tgt_go = 1'b1;
        end
      end
      HEAD_DOWN: begin
        stat.scan_done = any_lo || last_d;
        if (any_lo) begin
          tgt_go = 1'b1;
        end else if (any_hi) begin
          tgt_go = 1'b1;
          tgt_f  = hi_sel;
        end
      end
      default: begin
        // lower floor wins a tie at equal distance
        stat.scan_done = any_lo || any_hi || last_d;
        if (any_lo) begin
          tgt_go = 1'b1;
        end else if (any_hi) begin
          tgt_go = 1'b1;
          tgt_f  = hi_sel;
        end
      end
    endcase
  end

  always_comb begin
    fc_nxt     = fc_r;
    ft_nxt     = ft_r;
    dt_nxt     = dt_r;
    car_nxt    = car_r;
    mode_nxt   = mode_r;
    head_nxt   = head_r;
    mask_nxt   = mask_r;
    goal_nxt   = goal_r;
    travel_nxt = travel_r;
    door_nxt   = door_r;
    served_nxt = served_r;
    d_nxt      = d_r;
    lo_hit_nxt = lo_hit_r;
    hi_hit_nxt = hi_hit_r;
    lo_f_nxt   = lo_f_r;
    hi_f_nxt   = hi_f_r;
    trip_go    = 1'b0;
    trip_f     = tgt_f;
    arr_go     = 1'b0;
    arr_f      = moved;

    if (cmd.exec) begin
      served_nxt = '0;
      d_nxt      = '0;
      lo_hit_nxt = 1'b0;
      hi_hit_nxt = 1'b0;
      priority case (ev_r.kind)
        KIND_TICK: begin
          if (mode_r == MODE_RUN) begin
            if (travel_inc >= eff_tick(ft_r)) begin
              travel_nxt = '0;
              car_nxt    = moved;
              if ((moved == goal_r) || pend_at(mask_r, {1'b0, moved}, n_eff)) arr_go = 1'b1;
            end else begin
              travel_nxt = travel_inc;
            end
          end else if (mode_r == MODE_OPEN) begin
            if (door_inc >= eff_tick(dt_r)) begin
              mode_nxt = MODE_WAIT;
              door_nxt = '0;
            end else begin
              door_nxt = door_inc;
            end
          end
        end
        KIND_CALL: begin
          if ((mode_r != MODE_BROKEN) && call_ok) begin
            if ((ev_r.call_floor == car_r) && (mode_r == MODE_OPEN)) begin
              mask_nxt   = mask_r & ~floor_bit({1'b0, ev_r.call_floor});
              served_nxt = ev_r.call_floor;
            end else begin
              mask_nxt = mask_r | floor_bit({1'b0, ev_r.call_floor});
              if (mode_r == MODE_WAIT) begin
                trip_go = 1'b1;
                trip_f  = ev_r.call_floor;
              end
            end
          end
        end
        KIND_OPEN: begin
          if (mode_r == MODE_WAIT) begin
            mode_nxt = MODE_OPEN;
            door_nxt = '0;
          end
        end
        KIND_CLOSE: begin
          if (mode_r == MODE_OPEN) begin
            mode_nxt = MODE_WAIT;
            door_nxt = '0;
          end
        end
        KIND_ALARM: begin
          if (mode_r == MODE_BROKEN) begin
            mode_nxt = MODE_WAIT;
          end else begin
            mode_nxt   = MODE_BROKEN;
            head_nxt   = HEAD_NONE;
            travel_nxt = '0;
            door_nxt   = '0;
          end
          mask_nxt = '0;
        end
        default: ;
      endcase
    end

    if (cmd.scan_step) begin
      d_nxt = d_r + DW'(1);
      if (!lo_hit_r && lo_now) begin
        lo_hit_nxt = 1'b1;
        lo_f_nxt   = lo_f_now;
      end
      if (!hi_hit_r && hi_now) begin
        hi_hit_nxt = 1'b1;
        hi_f_nxt   = hi_f_now[FLOOR_W-1:0];
      end
    end

    if (cmd.pick) begin
      if (tgt_go) trip_go = 1'b1;
      else head_nxt = HEAD_NONE;
    end

    // start a trip; a trip to the own floor arrives at once
    if (trip_go) begin
      goal_nxt = trip_f;
      head_nxt = (trip_f > car_r) ? HEAD_UP : HEAD_DOWN;
      if (trip_f == car_r) begin
        arr_go = 1'b1;
        arr_f  = trip_f;
      end else begin
        mode_nxt   = MODE_RUN;
        travel_nxt = '0;
      end
    end

    if (arr_go) begin
      mask_nxt   = mask_nxt & ~floor_bit({1'b0, arr_f});
      served_nxt = arr_f;
      mode_nxt   = MODE_OPEN;
      door_nxt   = '0;
      travel_nxt = '0;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLOOR_COUNT: begin
          fc_nxt   = cfg_data[FLOOR_W-1:0];
          mask_nxt = mask_nxt & keep_bits(eff_cnt(cfg_data[FLOOR_W-1:0]));
        end
        CFG_FLOOR_TICKS: ft_nxt = cfg_data[TICK_W-1:0];
        CFG_DOOR_TICKS:  dt_nxt = cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign mask_wide = {{PEND_W{1'b0}}, mask_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r     <= RST_FLOOR_COUNT;
      ft_r     <= RST_FLOOR_TICKS;
      dt_r     <= RST_DOOR_TICKS;
      car_r    <= FLOOR_W'(1);
      mode_r   <= MODE_WAIT;
      head_r   <= HEAD_NONE;
      mask_r   <= '0;
      goal_r   <= FLOOR_W'(1);
      travel_r <= '0;
      door_r   <= '0;
      served_r <= '0;
    end else begin
      fc_r     <= fc_nxt;
      ft_r     <= ft_nxt;
      dt_r     <= dt_nxt;
      car_r    <= car_nxt;
      mode_r   <= mode_nxt;
      head_r   <= head_nxt;
      mask_r   <= mask_nxt;
      goal_r   <= goal_nxt;
      travel_r <= travel_nxt;
      door_r   <= door_nxt;
      served_r <= served_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) ev_r <= in_data;
    d_r      <= d_nxt;
    lo_hit_r <= lo_hit_nxt;
    hi_hit_r <= hi_hit_nxt;
    lo_f_r   <= lo_f_nxt;
    hi_f_r   <= hi_f_nxt;
    if (cmd.load_out) begin
      out_r.floor_now     <= car_r;
      out_r.mode          <= mode_r;
      out_r.heading       <= head_r;
      out_r.arrived_floor <= served_r;
      out_r.pending_calls <= mask_wide[PEND_W-1:0];
    end
  end

  assign out_data = out_r;

`ifndef NO_ASSERTIONS
  a_run_has_heading: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_RUN) |-> (head_r != HEAD_NONE))
    else $error("car running with no heading");

  a_mask_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mask_r & ~keep_bits(n_eff)) == '0)
    else $error("pending call above floor count");

  a_floor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    car_r != '0)
    else $error("car floor is zero");
`endif

endmodule

/* rtl/ecc_ctrl.sv */
module ecc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ecc_pkg::ecc_stat_t stat,
  output ecc_pkg::ecc_cmd_t  cmd
);
  import ecc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_PUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = stat.need_scan ? S_SCAN : S_PUT;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          cmd.pick  = 1'b1;
          state_nxt = S_PUT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_PUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> cmd.exec)
    else $error("accepted transaction not executed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  a_valid_from_put: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_PUT))
    else $error("result raised outside of delivery");
`endif

endmodule

/* rtl/elevator_car_controller_top.sv */
// Single-car elevator controller. Each input transaction is one event (tick, floor call,
// door open, door close, alarm) and produces exactly one result transaction carrying the
// car floor, mode, heading, the floor served by this event (0 if none) and the pending-call
// mask. One transaction is in work at a time: it passes capture, execute and deliver, and
// an event that closes the door adds a scan of the call mask for the next target between
// execute and deliver, one floor distance per cycle outward from the car. The result
// register lets the next event be accepted while the previous result still waits on
// out_ready. Configuration writes on cfg_we take effect at once and are meant for times
// when no event is in work; writing the floor count drops any pending call above the new
// count, saturated to [2, MAX_FLOORS].
module elevator_car_controller_top #(
  parameter int MAX_FLOORS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // event transactions
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ecc_pkg::ecc_in_t           in_data,
  // result transactions
  output logic                       out_valid,
  input  logic                       out_ready,
  output ecc_pkg::ecc_out_t          out_data,
  // configuration writes
  input  logic                       cfg_we,
  input  logic [ecc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [ecc_pkg::CFG_W-1:0]  cfg_data
);
  import ecc_pkg::*;

  // commands from the sequencer, status back from the datapath
  ecc_cmd_t  cmd;
  ecc_stat_t stat;

  // sequencer: capture, execute, optional next-target scan, deliver
  ecc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // car state, configuration registers, scan registers and result register
  ecc_dp #(
    .MAX_FLOORS (MAX_FLOORS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
